>>> sv/dnsae_pkg.sv
// ----------------------------------------------------------------------------
// dnsae_pkg
// Shared constants and the result record type of the DNS answer extractor.
// ----------------------------------------------------------------------------
package dnsae_pkg;

   // Record name byte with both top bits set starts a compression pointer
   localparam logic [7:0] PTR_MARK   = 8'hC0;

   // Byte position counter: covers header, question tail and fixed fields
   localparam int         POS_W      = 4;
   localparam logic [POS_W-1:0] HEADER_LEN = POS_W'(12);
   localparam logic [POS_W-1:0] QTAIL_LEN  = POS_W'(2 + 2);
   localparam logic [POS_W-1:0] FIXED_LEN  = POS_W'(10);
   localparam logic [POS_W-1:0] ADDR_LEN   = POS_W'(4);

   localparam logic [15:0] TYPE_A     = 16'd1;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

   localparam logic KIND_ADDR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Result queue: one input byte yields at most two results
   localparam int QUEUE_DEPTH = 3;
   localparam int MAX_PUSH    = 2;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic        kind;
      logic [31:0] ipv4_addr;
      logic [15:0] rec_class;
      logic [31:0] ttl_seconds;
      logic [15:0] found_count;
      logic        status;
      logic        end_flag;
   } result_type;

endpackage

>>> sv/dns_answer_a_record_extractor_top.sv
// ----------------------------------------------------------------------------
// dns_answer_a_record_extractor_top
// Walks a DNS response one byte per transfer and reports every A record
// (address, class, raw TTL) plus an end-of-message summary.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_data_byte, req_last
//  rsp     | out       | rsp_valid/rsp_stall | rsp_kind ... rsp_end_flag
//
//  One byte is taken per cycle while req is not stalled; parse state updates in the same cycle and
//  results land in a three-entry result queue, shown on rsp the next cycle when no older result is ahead.
//  A byte that yields two results (A record on the last byte) queues both of them;
//  req stalls only when the queue cannot take two more results.
//  Reset is synchronous and returns to the header phase with the queue empty.
module dns_answer_a_record_extractor_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [31:0] rsp_ipv4_addr,
   output logic [15:0] rsp_rec_class,
   output logic [31:0] rsp_ttl_seconds,
   output logic [15:0] rsp_found_count,
   output logic        rsp_status,
   output logic        rsp_end_flag
);

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_QNAME  = 3'd1,
      PH_QTAIL  = 3'd2,
      PH_RNAME  = 3'd3,
      PH_RPTR   = 3'd4,
      PH_FIXED  = 3'd5,
      PH_RDATA  = 3'd6,
      PH_DONE   = 3'd7
   } phase_type;

   localparam int PW = dnsae_pkg::POS_W;
   localparam int QW = dnsae_pkg::QCNT_W;

   phase_type       phase_ff, phase_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic [16:0]     records_ff, records_in;
   logic [7:0]      label_ff, label_in;
   logic [15:0]     rdata_ff, rdata_in;
   logic [15:0]     type_ff, type_in;
   logic [15:0]     class_ff, class_in;
   logic [31:0]     ttl_ff, ttl_in;
   logic [31:0]     addr_ff, addr_in;
   logic [15:0]     found_ff, found_in;

   dnsae_pkg::result_type queue_ff [dnsae_pkg::QUEUE_DEPTH];
   dnsae_pkg::result_type queue_in [dnsae_pkg::QUEUE_DEPTH];
   logic [QW-1:0]   qcnt_ff, qcnt_in;
   logic [QW-1:0]   qcnt_mid;

   logic            req_fire, rsp_fire;
   logic            finish, addr_hit;
   logic [31:0]     fin_addr;
   dnsae_pkg::result_type res0, res1;
   logic [QW-1:0]   push_cnt;

   assign rsp_valid = (qcnt_ff != '0);
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign qcnt_mid  = qcnt_ff - QW'(rsp_fire);
   assign req_stall = (qcnt_mid > QW'(dnsae_pkg::QUEUE_DEPTH - dnsae_pkg::MAX_PUSH));
   assign req_fire  = req_valid && !req_stall;

   assign rsp_kind        = queue_ff[0].kind;
   assign rsp_ipv4_addr   = queue_ff[0].ipv4_addr;
   assign rsp_rec_class   = queue_ff[0].rec_class;
   assign rsp_ttl_seconds = queue_ff[0].ttl_seconds;
   assign rsp_found_count = queue_ff[0].found_count;
   assign rsp_status      = queue_ff[0].status;
   assign rsp_end_flag    = queue_ff[0].end_flag;

   // Parse step for one byte
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      records_in = records_ff;
      label_in   = label_ff;
      rdata_in   = rdata_ff;
      type_in    = type_ff;
      class_in   = class_ff;
      ttl_in     = ttl_ff;
      addr_in    = addr_ff;
      found_in   = found_ff;
      finish     = 1'b0;

      unique case (phase_ff)
         PH_HEADER: begin
            if (pos_ff == PW'(6)) begin
               records_in = {1'b0, req_data_byte, 8'h00};
            end else if (pos_ff == PW'(7)) begin
               records_in = records_ff | {9'h000, req_data_byte};
            end else if (pos_ff == PW'(8)) begin
               label_in = req_data_byte;
            end else if (pos_ff == PW'(9)) begin
               records_in = records_ff + {1'b0, label_ff, req_data_byte};
               label_in   = '0;
            end
            pos_in = pos_ff + PW'(1);
            if (pos_in >= dnsae_pkg::HEADER_LEN) begin
               pos_in   = '0;
               label_in = '0;
               phase_in = PH_QNAME;
            end
         end
         PH_QNAME: begin
            if (label_ff != '0) begin
               label_in = label_ff - 8'd1;
            end else if (req_data_byte == 8'h00) begin
               pos_in   = '0;
               phase_in = PH_QTAIL;
            end else begin
               label_in = req_data_byte;
            end
         end
         PH_QTAIL: begin
            pos_in = pos_ff + PW'(1);
            if (pos_in >= dnsae_pkg::QTAIL_LEN) begin
               pos_in   = '0;
               label_in = '0;
               phase_in = (records_ff != '0) ? PH_RNAME : PH_DONE;
            end
         end
         PH_RNAME: begin
            if (label_ff != '0) begin
               label_in = label_ff - 8'd1;
            end else if ((req_data_byte & dnsae_pkg::PTR_MARK) == dnsae_pkg::PTR_MARK) begin
               phase_in = PH_RPTR;
            end else if (req_data_byte == 8'h00) begin
               pos_in   = '0;
               phase_in = PH_FIXED;
            end else begin
               label_in = req_data_byte;
            end
         end
         PH_RPTR: begin
            pos_in   = '0;
            phase_in = PH_FIXED;
         end
         PH_FIXED: begin
            if (pos_ff == '0) begin
               addr_in = '0;
            end
            if (pos_ff < PW'(2)) begin
               type_in = {(pos_ff == '0) ? 8'h00 : type_ff[7:0], req_data_byte};
            end else if (pos_ff < PW'(4)) begin
               class_in = {class_ff[7:0], req_data_byte};
            end else if (pos_ff < PW'(8)) begin
               ttl_in = {ttl_ff[23:0], req_data_byte};
            end else begin
               rdata_in = {rdata_ff[7:0], req_data_byte};
            end
            pos_in = pos_ff + PW'(1);
            if (pos_in >= dnsae_pkg::FIXED_LEN) begin
               pos_in = '0;
               if (rdata_in == '0) begin
                  finish = 1'b1;
               end else begin
                  phase_in = PH_RDATA;
               end
            end
         end
         PH_RDATA: begin
            // Count rdata bytes only up to the address length
            if (pos_ff < dnsae_pkg::ADDR_LEN) begin
               addr_in = {addr_ff[23:0], req_data_byte};
               pos_in  = pos_ff + PW'(1);
            end
            if (rdata_ff != '0) begin
               rdata_in = rdata_ff - 16'd1;
            end
            if (rdata_in == '0) begin
               finish = 1'b1;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      // Left-align a short address: missing bytes read as zero
      case (pos_in)
         PW'(0):  fin_addr = '0;
         PW'(1):  fin_addr = {addr_in[7:0], 24'h000000};
         PW'(2):  fin_addr = {addr_in[15:0], 16'h0000};
         PW'(3):  fin_addr = {addr_in[23:0], 8'h00};
         default: fin_addr = addr_in;
      endcase

      addr_hit = finish && (type_in == dnsae_pkg::TYPE_A);
      if (addr_hit && (found_ff != dnsae_pkg::COUNT_MAX)) begin
         found_in = found_ff + 16'd1;
      end
      if (finish) begin
         if (records_in != '0) begin
            records_in = records_in - 17'd1;
         end
         pos_in   = '0;
         label_in = '0;
         phase_in = (records_in != '0) ? PH_RNAME : PH_DONE;
      end

      res0             = '0;
      res1             = '0;
      res1.kind        = dnsae_pkg::KIND_END;
      res1.found_count = found_in;
      res1.status      = (phase_in != PH_DONE);
      res1.end_flag    = 1'b1;
      if (addr_hit) begin
         res0.kind        = dnsae_pkg::KIND_ADDR;
         res0.ipv4_addr   = fin_addr;
         res0.rec_class   = class_in;
         res0.ttl_seconds = ttl_in;
         res0.found_count = found_in;
         res0.end_flag    = !req_last;
      end else begin
         res0 = res1;
      end
      push_cnt = QW'(addr_hit) + QW'(req_last);

      // Drop all parse state after the final byte
      if (req_last) begin
         phase_in   = PH_HEADER;
         pos_in     = '0;
         records_in = '0;
         label_in   = '0;
         rdata_in   = '0;
         type_in    = '0;
         class_in   = '0;
         ttl_in     = '0;
         addr_in    = '0;
         found_in   = '0;
      end
   end

   // Result queue: head at entry 0, advance on rsp transfer
   always_comb begin
      for (int i = 0; i < dnsae_pkg::QUEUE_DEPTH - 1; i++) begin
         queue_in[i] = rsp_fire ? queue_ff[i+1] : queue_ff[i];
      end
      queue_in[dnsae_pkg::QUEUE_DEPTH-1] = queue_ff[dnsae_pkg::QUEUE_DEPTH-1];
      qcnt_in = qcnt_mid;
      if (req_fire) begin
         for (int i = 0; i < dnsae_pkg::QUEUE_DEPTH; i++) begin
            if ((QW'(i) == qcnt_mid) && (push_cnt != '0)) begin
               queue_in[i] = res0;
            end
            if ((QW'(i) == qcnt_mid + QW'(1)) && (push_cnt == QW'(2))) begin
               queue_in[i] = res1;
            end
         end
         qcnt_in = qcnt_mid + push_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         pos_ff     <= '0;
         records_ff <= '0;
         label_ff   <= '0;
         rdata_ff   <= '0;
         type_ff    <= '0;
         class_ff   <= '0;
         ttl_ff     <= '0;
         addr_ff    <= '0;
         found_ff   <= '0;
         qcnt_ff    <= '0;
      end else begin
         qcnt_ff <= qcnt_in;
         if (req_fire) begin
            phase_ff   <= phase_in;
            pos_ff     <= pos_in;
            records_ff <= records_in;
            label_ff   <= label_in;
            rdata_ff   <= rdata_in;
            type_ff    <= type_in;
            class_ff   <= class_in;
            ttl_ff     <= ttl_in;
            addr_ff    <= addr_in;
            found_ff   <= found_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < dnsae_pkg::QUEUE_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

   a_qcnt_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= QW'(dnsae_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_last) |=> (rsp_valid && (qcnt_ff != '0)))
      else $error("final byte left no result");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_last) |=> ((phase_ff == PH_HEADER) && (found_ff == '0)))
      else $error("parse state not cleared after final byte");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> (records_ff == '0))
      else $error("parsing ended with records left");

endmodule

>>> verif/dns_answer_a_record_extractor_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_answer_a_record_extractor_top_tb
// Streams DNS response messages into the extractor one byte per transfer.
// The messages are mostly well formed, with some noise and truncated ones.
// A byte-level parser model in the bench predicts every address record and
// every end-of-message summary. Each result transfer is checked field by
// field against the oldest prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module dns_answer_a_record_extractor_top_tb;

   typedef enum logic [3:0] {
      WALK_HEADER, WALK_QNAME, WALK_QTAIL, WALK_RNAME,
      WALK_RPTR, WALK_FIXED, WALK_RDATA, WALK_DONE
   } walk_type;

   typedef struct {
      logic [7:0] data;
      bit         last;
      bit         drain;
   } msg_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [31:0] rsp_ipv4_addr;
   logic [15:0] rsp_rec_class;
   logic [31:0] rsp_ttl_seconds;
   logic [15:0] rsp_found_count;
   logic        rsp_status;
   logic        rsp_end_flag;

   msg_byte_type          byte_stream[$];
   logic [7:0]            msg_bytes[$];
   dnsae_pkg::result_type answer_queue[$];
   int          accepted_bytes = 0;
   int          total_bytes = 0;
   int          mismatch_count = 0;
   int          hold_left = 0;
   int          holds_started = 0;
   logic        quiet;

   // parser state of the model
   walk_type    walk_phase;
   logic [15:0] pos;
   logic [16:0] recs_left;
   logic [7:0]  lbl_left;
   logic [15:0] rd_left;
   logic [15:0] rtype;
   logic [15:0] rclass;
   logic [31:0] rttl;
   logic [31:0] raddr;
   logic [15:0] a_total;

   dns_answer_a_record_extractor_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_ipv4_addr   (rsp_ipv4_addr),
      .rsp_rec_class   (rsp_rec_class),
      .rsp_ttl_seconds (rsp_ttl_seconds),
      .rsp_found_count (rsp_found_count),
      .rsp_status      (rsp_status),
      .rsp_end_flag    (rsp_end_flag)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // no idling on either side through this stretch
   assign quiet = accepted_bytes >= 800 && accepted_bytes < 1100;

   function automatic void reset_walker();
      walk_phase = WALK_HEADER;
      pos = '0;
      recs_left = '0;
      lbl_left = '0;
      rd_left = '0;
      rtype = '0;
      rclass = '0;
      rttl = '0;
      raddr = '0;
      a_total = '0;
   endfunction

   function automatic void enter_records();
      pos = '0;
      lbl_left = '0;
      walk_phase = (recs_left != 0) ? WALK_RNAME : WALK_DONE;
   endfunction

   function automatic int close_record();
      logic [15:0] taken;
      logic [31:0] addr;
      int          emitted;
      emitted = 0;
      if (rtype == dnsae_pkg::TYPE_A) begin
         // missing rdata bytes read as zero below the present ones
         taken = (pos < 16'(dnsae_pkg::ADDR_LEN)) ? pos : 16'(dnsae_pkg::ADDR_LEN);
         addr = (taken == 0) ? 32'h0 : raddr << (8 * (4 - taken));
         if (a_total != dnsae_pkg::COUNT_MAX) a_total = a_total + 16'd1;
         answer_queue.push_back('{kind: dnsae_pkg::KIND_ADDR, ipv4_addr: addr,
                                  rec_class: rclass, ttl_seconds: rttl,
                                  found_count: a_total, status: 1'b0, end_flag: 1'b0});
         emitted = 1;
      end
      if (recs_left != 0) recs_left = recs_left - 17'd1;
      enter_records();
      return emitted;
   endfunction

   task automatic parse_byte(input logic [7:0] b, input logic is_last);
      int                    produced;
      dnsae_pkg::result_type tail;
      produced = 0;
      case (walk_phase)
         WALK_HEADER: begin
            if (pos == 6) recs_left = {1'b0, b, 8'h00};
            else if (pos == 7) recs_left = recs_left | {9'd0, b};
            else if (pos == 8) lbl_left = b;
            else if (pos == 9) begin
               recs_left = recs_left + {1'b0, lbl_left, b};
               lbl_left = '0;
            end
            pos = pos + 16'd1;
            if (pos >= 16'(dnsae_pkg::HEADER_LEN)) begin
               pos = '0;
               lbl_left = '0;
               walk_phase = WALK_QNAME;
            end
         end
         WALK_QNAME: begin
            // question labels never honor pointers
            if (lbl_left != 0) lbl_left = lbl_left - 8'd1;
            else if (b == 8'h00) begin
               pos = '0;
               walk_phase = WALK_QTAIL;
            end else lbl_left = b;
         end
         WALK_QTAIL: begin
            pos = pos + 16'd1;
            if (pos >= 16'(dnsae_pkg::QTAIL_LEN)) enter_records();
         end
         WALK_RNAME: begin
            if (lbl_left != 0) lbl_left = lbl_left - 8'd1;
            else if ((b & dnsae_pkg::PTR_MARK) == dnsae_pkg::PTR_MARK)
               walk_phase = WALK_RPTR;
            else if (b == 8'h00) begin
               pos = '0;
               walk_phase = WALK_FIXED;
            end else lbl_left = b;
         end
         WALK_RPTR: begin
            pos = '0;
            walk_phase = WALK_FIXED;
         end
         WALK_FIXED: begin
            if (pos == 0) begin
               rtype = '0;
               raddr = '0;
            end
            if (pos < 2) rtype = {rtype[7:0], b};
            else if (pos < 4) rclass = {rclass[7:0], b};
            else if (pos < 8) rttl = {rttl[23:0], b};
            else rd_left = {rd_left[7:0], b};
            pos = pos + 16'd1;
            if (pos >= 16'(dnsae_pkg::FIXED_LEN)) begin
               pos = '0;
               if (rd_left == 0) produced += close_record();
               else walk_phase = WALK_RDATA;
            end
         end
         WALK_RDATA: begin
            if (pos < 16'(dnsae_pkg::ADDR_LEN)) raddr = {raddr[23:0], b};
            if (pos != 16'hFFFF) pos = pos + 16'd1;
            if (rd_left != 0) rd_left = rd_left - 16'd1;
            if (rd_left == 0) produced += close_record();
         end
         default: ;
      endcase
      if (is_last) begin
         answer_queue.push_back('{kind: dnsae_pkg::KIND_END, ipv4_addr: 32'h0,
                                  rec_class: 16'h0, ttl_seconds: 32'h0,
                                  found_count: a_total,
                                  status: (walk_phase != WALK_DONE), end_flag: 1'b0});
         produced++;
         reset_walker();
      end
      if (produced > 0) begin
         tail = answer_queue.pop_back();
         tail.end_flag = 1'b1;
         answer_queue.push_back(tail);
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100) $display("ERROR at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   task automatic check_result();
      dnsae_pkg::result_type want;
      if (answer_queue.size() == 0) begin
         report_mismatch("result transfer with nothing predicted");
         return;
      end
      want = answer_queue.pop_front();
      check_field("kind", 32'(rsp_kind), 32'(want.kind));
      check_field("ipv4_addr", rsp_ipv4_addr, want.ipv4_addr);
      check_field("rec_class", 32'(rsp_rec_class), 32'(want.rec_class));
      check_field("ttl_seconds", rsp_ttl_seconds, want.ttl_seconds);
      check_field("found_count", 32'(rsp_found_count), 32'(want.found_count));
      check_field("status", 32'(rsp_status), 32'(want.status));
      check_field("end_flag", 32'(rsp_end_flag), 32'(want.end_flag));
   endtask

   function automatic void append_random(int unsigned count);
      for (int unsigned i = 0; i < count; i++) msg_bytes.push_back(8'($urandom));
   endfunction

   function automatic void append_labels(int unsigned count, int unsigned long_lo,
                                         int unsigned long_hi);
      int unsigned len;
      for (int unsigned i = 0; i < count; i++) begin
         len = ($urandom_range(29) == 0) ? $urandom_range(long_hi, long_lo)
                                         : $urandom_range(8, 1);
         msg_bytes.push_back(8'(len));
         append_random(len);
      end
   endfunction

   function automatic void queue_message(bit drain);
      for (int i = 0; i < msg_bytes.size(); i++)
         byte_stream.push_back('{data: msg_bytes[i], last: (i == msg_bytes.size() - 1),
                                 drain: (drain && i == 0)});
      msg_bytes = {};
   endfunction

   task automatic build_message(input bit drain);
      int unsigned ancount;
      int unsigned nscount;
      int unsigned nrec;
      int unsigned rdlen;
      int unsigned name_pick;
      int unsigned cut;
      bit          is_a;
      msg_bytes = {};
      if ($urandom_range(99) < 5) begin
         append_random($urandom_range(40, 1));
      end else begin
         ancount = $urandom_range(4);
         nscount = $urandom_range(2);
         if ($urandom_range(14) == 0) begin
            ancount = $urandom_range(16'hFFFF);
            nscount = $urandom_range(16'hFFFF);
            if ($urandom_range(1) == 0) begin
               ancount = 16'hFFFF;
               nscount = 16'hFFFF;
            end
         end
         append_random(12);
         msg_bytes[6] = 8'(ancount >> 8);
         msg_bytes[7] = 8'(ancount);
         msg_bytes[8] = 8'(nscount >> 8);
         msg_bytes[9] = 8'(nscount);
         // question label lengths may carry pointer-like top bits
         append_labels($urandom_range(3), 192, 255);
         msg_bytes.push_back(8'h00);
         append_random(4);
         nrec = ancount + nscount;
         if (nrec > 6) nrec = $urandom_range(6, 1);
         if ($urandom_range(9) == 0) nrec = nrec + 1;
         else if (nrec != 0 && $urandom_range(9) == 0) nrec = nrec - 1;
         repeat (nrec) begin
            name_pick = $urandom_range(2);
            if (name_pick != 0) append_labels($urandom_range(3, 1), 64, 191);
            if (name_pick == 1) msg_bytes.push_back(8'h00);
            else begin
               msg_bytes.push_back(dnsae_pkg::PTR_MARK | 8'($urandom_range(63)));
               append_random(1);
            end
            is_a = $urandom_range(99) < 60;
            if (is_a) begin
               msg_bytes.push_back(dnsae_pkg::TYPE_A[15:8]);
               msg_bytes.push_back(dnsae_pkg::TYPE_A[7:0]);
            end else append_random(2);
            if ($urandom_range(1) == 0) begin
               msg_bytes.push_back(8'h00);
               msg_bytes.push_back(8'h01);
            end else append_random(2);
            append_random(4);
            if ($urandom_range(39) == 0) rdlen = $urandom_range(300, 256);
            else if (is_a && $urandom_range(3) != 0) rdlen = 4;
            else rdlen = $urandom_range(8);
            msg_bytes.push_back(8'(rdlen >> 8));
            msg_bytes.push_back(8'(rdlen));
            append_random(rdlen);
         end
         if ($urandom_range(4) == 0) append_random($urandom_range(4, 1));
         if ($urandom_range(9) == 0) begin
            cut = $urandom_range(msg_bytes.size(), 1);
            while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
         end
      end
      queue_message(drain);
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      msg_byte_type next_byte;
      bit           may_load;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_data_byte, req_last);
            accepted_bytes <= accepted_bytes + 1;
         end
         if (!req_valid || !req_stall) begin
            may_load = byte_stream.size() != 0 && (quiet || $urandom_range(99) >= 26);
            // hold a draining message until every prior result is back
            if (may_load && byte_stream[0].drain && answer_queue.size() != 0)
               may_load = 1'b0;
            if (may_load) begin
               next_byte = byte_stream.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_byte.data;
               req_last <= next_byte.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-offs so the block backs up into req_stall
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         holds_started <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if ((holds_started == 0 && accepted_bytes >= 300) ||
                   (holds_started == 1 && accepted_bytes >= 1300)) begin
         hold_left <= 150;
         holds_started <= holds_started + 1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         rsp_stall <= hold_left != 0 || (!quiet && $urandom_range(99) < 26);
      end
   end

   initial begin
      int msg_index;
      reset_walker();
      // early end on the very first byte
      msg_bytes = {8'hFF};
      queue_message(1'b0);
      // zero record count, then trailing bytes that are ignored
      msg_bytes = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                   8'hFF, 8'h00, 8'hFF};
      queue_message(1'b0);
      msg_index = 0;
      while (byte_stream.size() < 1750) begin
         build_message(msg_index == 3 || msg_index == 9);
         msg_index++;
      end
      total_bytes = byte_stream.size();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (accepted_bytes != total_bytes || answer_queue.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && answer_queue.size() == 0) begin
         $display("dns_answer_a_record_extractor_top_tb OK");
      end else begin
         $display("dns_answer_a_record_extractor_top_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("dns_answer_a_record_extractor_top_tb NOT OK");
      $finish;
   end

endmodule
